>>> rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants of the mixed-radix index counter: commands,
// sequencer states and the request/response bundles of the serial units.
// ----------------------------------------------------------------------------
package mrc_pkg;

	localparam int MAX_DIMS    = 4;
	localparam int RADIX_W     = 9;
	localparam int FLAT_W      = 32;
	localparam int CMD_W       = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int OUT_DIGIT_W = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_START,
		ST_LOAD_WAIT,
		ST_STEP,
		ST_SUM_INIT,
		ST_SUM_START,
		ST_SUM_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic               start;
		logic [FLAT_W-1:0]  dividend;
		logic [RADIX_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [FLAT_W-1:0]  quotient;
		logic [RADIX_W-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic               start;
		logic [FLAT_W-1:0]  mcand;
		logic [RADIX_W-1:0] mplier;
		logic [FLAT_W-1:0]  addend;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic [FLAT_W-1:0] result;
	} mul_rsp_t;

endpackage

>>> rtl/mrc_div.sv
// ----------------------------------------------------------------------------
// mrc_div
// Bit-serial restoring divider: 32-bit dividend by 9-bit divisor, one
// quotient bit per cycle, done pulse registered together with the last bit.
// ----------------------------------------------------------------------------
module mrc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  mrc_pkg::div_req_t req,
	output mrc_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(mrc_pkg::FLAT_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [mrc_pkg::FLAT_W-1:0]  quo_q;
	logic [mrc_pkg::RADIX_W-1:0] rem_q;
	logic [mrc_pkg::RADIX_W-1:0] div_q;

	logic [mrc_pkg::RADIX_W:0]   rem_sh;
	logic                        ge;
	logic [mrc_pkg::RADIX_W-1:0] rem_nx;

	always_comb begin
		rem_sh = {rem_q, quo_q[mrc_pkg::FLAT_W-1]};
		ge     = rem_sh >= {1'b0, div_q};
		rem_nx = ge ? mrc_pkg::RADIX_W'(rem_sh - {1'b0, div_q})
		            : rem_sh[mrc_pkg::RADIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(mrc_pkg::FLAT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[mrc_pkg::FLAT_W-2:0], ge};
			rem_q <= rem_nx;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

>>> rtl/mrc_mul.sv
// ----------------------------------------------------------------------------
// mrc_mul
// Bit-serial shift-add multiply-accumulate: mcand * mplier + addend modulo
// 2^32, one multiplier bit per cycle, done pulse after the last bit.
// ----------------------------------------------------------------------------
module mrc_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mrc_pkg::mul_req_t req,
	output mrc_pkg::mul_rsp_t rsp
);

	localparam int CNT_W = $clog2(mrc_pkg::RADIX_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [mrc_pkg::FLAT_W-1:0]  mcand_q;
	logic [mrc_pkg::RADIX_W-1:0] mplier_q;
	logic [mrc_pkg::FLAT_W-1:0]  prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(mrc_pkg::RADIX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			mcand_q  <= req.mcand;
			mplier_q <= req.mplier;
			prod_q   <= req.addend;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				prod_q <= prod_q + mcand_q;
			end
			mcand_q  <= {mcand_q[mrc_pkg::FLAT_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[mrc_pkg::RADIX_W-1:1]};
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = prod_q;

endmodule

>>> rtl/mixed_radix_index_counter.sv
// ----------------------------------------------------------------------------
// mixed_radix_index_counter
// Mixed-radix digit counter with clear, load from flat index, step and read.
// ----------------------------------------------------------------------------
// One command is worked on at a time; the next one is taken as soon as the
// sequencer is back in idle, even while the previous result still waits at
// the output register. A load runs the bit-serial divider once per
// dimension; the flat index is then rebuilt by the bit-serial multiplier,
// once per dimension below the top one. A step walks up the dimensions
// only as far as the carry runs. Radix writes land on the next edge;
// dimensions at or above NUM_DIMS read as zero.
module mixed_radix_index_counter #(
	parameter int NUM_DIMS   = 4,
	parameter int DIGIT_BITS = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_en,
	input  logic [mrc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mrc_pkg::RADIX_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [mrc_pkg::CMD_W-1:0]           command,
	input  logic [mrc_pkg::FLAT_W-1:0]          flat_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [mrc_pkg::FLAT_W-1:0]          flat_out,
	output logic [mrc_pkg::OUT_DIGIT_W-1:0]     digit_0,
	output logic [mrc_pkg::OUT_DIGIT_W-1:0]     digit_1,
	output logic [mrc_pkg::OUT_DIGIT_W-1:0]     digit_2,
	output logic [mrc_pkg::OUT_DIGIT_W-1:0]     digit_3,
	output logic                                more_left
);

	localparam int DIM_W = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;
	localparam logic [DIM_W-1:0] DIM_TOP = DIM_W'(NUM_DIMS - 1);
	localparam logic [mrc_pkg::RADIX_W-1:0] RADIX_CAP = mrc_pkg::RADIX_W'(1 << DIGIT_BITS);

	mrc_pkg::state_t state_q, state_nx;

	logic [mrc_pkg::RADIX_W-1:0]     radix_q [NUM_DIMS];
	logic [DIGIT_BITS-1:0]           digits_q [NUM_DIMS];
	logic [DIM_W-1:0]                dim_q;
	logic [mrc_pkg::FLAT_W-1:0]      acc_q;
	logic                            more_q;

	logic                            out_valid_q;
	logic [mrc_pkg::FLAT_W-1:0]      flat_out_q;
	logic [mrc_pkg::OUT_DIGIT_W-1:0] dig_out_q [mrc_pkg::MAX_DIMS];
	logic                            more_out_q;

	logic [mrc_pkg::OUT_DIGIT_W-1:0] dig_view [mrc_pkg::MAX_DIMS];
	logic [mrc_pkg::RADIX_W-1:0]     raw_r;
	logic [mrc_pkg::RADIX_W-1:0]     eff_r;
	logic [DIGIT_BITS-1:0]           cur_dig;
	logic                            dig_lt;
	logic                            in_take;
	logic                            out_free;
	mrc_pkg::cmd_t                   cmd;

	mrc_pkg::div_req_t div_req;
	mrc_pkg::div_rsp_t div_rsp;
	mrc_pkg::mul_req_t mul_req;
	mrc_pkg::mul_rsp_t mul_rsp;

	mrc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mrc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	always_comb begin
		cmd     = mrc_pkg::cmd_t'(command);
		raw_r   = radix_q[dim_q];
		cur_dig = digits_q[dim_q];
		if (raw_r == '0) begin
			eff_r = mrc_pkg::RADIX_W'(1);
		end else if (raw_r > RADIX_CAP) begin
			eff_r = RADIX_CAP;
		end else begin
			eff_r = raw_r;
		end
		dig_lt   = mrc_pkg::RADIX_W'(cur_dig) < (eff_r - 1'b1);
		in_take  = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
	end

	for (genvar k = 0; k < mrc_pkg::MAX_DIMS; k++) begin : g_view
		if (k < NUM_DIMS) begin : g_used
			assign dig_view[k] = mrc_pkg::OUT_DIGIT_W'(digits_q[k]);
		end else begin : g_unused
			assign dig_view[k] = '0;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			mrc_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (cmd)
						mrc_pkg::CMD_LOAD: state_nx = mrc_pkg::ST_LOAD_START;
						mrc_pkg::CMD_STEP: state_nx = mrc_pkg::ST_STEP;
						default:           state_nx = mrc_pkg::ST_SUM_INIT;
					endcase
				end
			end
			mrc_pkg::ST_LOAD_START: state_nx = mrc_pkg::ST_LOAD_WAIT;
			mrc_pkg::ST_LOAD_WAIT: begin
				if (div_rsp.done) begin
					state_nx = (dim_q == DIM_TOP) ? mrc_pkg::ST_SUM_INIT
					                              : mrc_pkg::ST_LOAD_START;
				end
			end
			mrc_pkg::ST_STEP: begin
				if (dig_lt || dim_q == DIM_TOP) begin
					state_nx = mrc_pkg::ST_SUM_INIT;
				end
			end
			mrc_pkg::ST_SUM_INIT: begin
				state_nx = (dim_q == '0) ? mrc_pkg::ST_FINISH : mrc_pkg::ST_SUM_START;
			end
			mrc_pkg::ST_SUM_START: state_nx = mrc_pkg::ST_SUM_WAIT;
			mrc_pkg::ST_SUM_WAIT: begin
				if (mul_rsp.done) begin
					state_nx = (dim_q == '0) ? mrc_pkg::ST_FINISH : mrc_pkg::ST_SUM_START;
				end
			end
			mrc_pkg::ST_FINISH: begin
				if (out_free) begin
					state_nx = mrc_pkg::ST_IDLE;
				end
			end
			default: state_nx = mrc_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall         = (state_q != mrc_pkg::ST_IDLE);
		div_req.start    = (state_q == mrc_pkg::ST_LOAD_START);
		div_req.dividend = acc_q;
		div_req.divisor  = eff_r;
		mul_req.start    = (state_q == mrc_pkg::ST_SUM_START);
		mul_req.mcand    = acc_q;
		mul_req.mplier   = eff_r;
		mul_req.addend   = mrc_pkg::FLAT_W'(cur_dig);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mrc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < NUM_DIMS; i++) begin
				radix_q[i]  <= mrc_pkg::RADIX_W'(2);
				digits_q[i] <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (cfg_en && ({1'b0, cfg_index} < (mrc_pkg::CFG_IDX_W + 1)'(NUM_DIMS))) begin
				radix_q[cfg_index[DIM_W-1:0]] <= cfg_data;
			end
			if (state_q == mrc_pkg::ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				mrc_pkg::ST_IDLE: begin
					if (in_take && cmd == mrc_pkg::CMD_CLEAR) begin
						for (int i = 0; i < NUM_DIMS; i++) begin
							digits_q[i] <= '0;
						end
					end
				end
				mrc_pkg::ST_LOAD_WAIT: begin
					if (div_rsp.done) begin
						digits_q[dim_q] <= div_rsp.remainder[DIGIT_BITS-1:0];
					end
				end
				mrc_pkg::ST_STEP: begin
					digits_q[dim_q] <= dig_lt ? cur_dig + 1'b1 : '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= '0;
		end else begin
			case (state_q)
				mrc_pkg::ST_IDLE: begin
					if (in_take) begin
						dim_q <= (cmd == mrc_pkg::CMD_LOAD || cmd == mrc_pkg::CMD_STEP)
						         ? '0 : DIM_TOP;
					end
				end
				mrc_pkg::ST_LOAD_WAIT: begin
					if (div_rsp.done && dim_q != DIM_TOP) begin
						dim_q <= dim_q + 1'b1;
					end
				end
				mrc_pkg::ST_STEP: begin
					if (dig_lt) begin
						dim_q <= DIM_TOP;
					end else if (dim_q != DIM_TOP) begin
						dim_q <= dim_q + 1'b1;
					end
				end
				mrc_pkg::ST_SUM_INIT: begin
					if (dim_q != '0) begin
						dim_q <= dim_q - 1'b1;
					end
				end
				mrc_pkg::ST_SUM_WAIT: begin
					if (mul_rsp.done && dim_q != '0) begin
						dim_q <= dim_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mrc_pkg::ST_IDLE: begin
				if (in_take) begin
					acc_q <= flat_in;
				end
			end
			mrc_pkg::ST_LOAD_WAIT: begin
				if (div_rsp.done) begin
					acc_q <= div_rsp.quotient;
				end
			end
			mrc_pkg::ST_SUM_INIT: begin
				acc_q  <= mrc_pkg::FLAT_W'(cur_dig);
				more_q <= dig_lt;
			end
			mrc_pkg::ST_SUM_START: begin
				more_q <= more_q || dig_lt;
			end
			mrc_pkg::ST_SUM_WAIT: begin
				if (mul_rsp.done) begin
					acc_q <= mul_rsp.result;
				end
			end
			mrc_pkg::ST_FINISH: begin
				if (out_free) begin
					flat_out_q <= acc_q;
					more_out_q <= more_q;
					for (int i = 0; i < mrc_pkg::MAX_DIMS; i++) begin
						dig_out_q[i] <= dig_view[i];
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign flat_out  = flat_out_q;
	assign digit_0   = dig_out_q[0];
	assign digit_1   = dig_out_q[1];
	assign digit_2   = dig_out_q[2];
	assign digit_3   = dig_out_q[3];
	assign more_left = more_out_q;

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> state_q != mrc_pkg::ST_IDLE)
		else $error("accepted beat did not start work");

	a_div_done_in_load: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == mrc_pkg::ST_LOAD_WAIT)
		else $error("divider finished outside a load");

	a_mul_done_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> state_q == mrc_pkg::ST_SUM_WAIT)
		else $error("multiplier finished outside the index sum");

	a_dim_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		dim_q <= DIM_TOP)
		else $error("dimension counter out of range");

	a_finish_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mrc_pkg::ST_FINISH && out_valid && out_stall)
		|=> state_q == mrc_pkg::ST_FINISH && out_valid)
		else $error("result dropped while output held");

endmodule
